@@ src/assert_macros.svh @@
// assertion macros used by the weighted sampling unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WSW_ASSERT(label, clk, rst, prop, msg) \
label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WSW_ASSERT_NR(label, clk, prop, msg) \
label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSW_ASSERT(label, clk, rst, prop, msg)
`define WSW_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ src/wsw_pkg.sv @@
// shared constants and types for the weighted sampling unit
package wsw_pkg;
   localparam int unsigned TABLE_DEPTH_DEF = 64;
   localparam int unsigned WEIGHT_W = 15;
   localparam int unsigned TOTAL_W = 21;
   localparam int unsigned CNT_W = 7;

   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_LOAD = 2'd1;
   localparam logic [1:0] FUNC_DRAW = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_PICKED = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   localparam logic [WEIGHT_W-1:0] W_NO_ATTEMPT = 15'd5000;
   localparam logic [WEIGHT_W-1:0] W_NO_FAILURE = 15'd10000;
   localparam logic [31:0] FAIL_SCALE = 32'd1000;
   localparam logic [13:0] RATIO_SCALE = 14'd10000;

   // divider start request
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   // divider result
   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;
endpackage

@@ src/weighted_sample_without_replacement_unit.sv @@
// Weighted sampling without replacement over a table of candidate weights.
// Per item: clear empties the table; load runs two 64-step divisions on the
// shared divider, skipped when attempts or failures are zero; draw scales and
// folds the random value if more are loaded than max_picks, then reads and tests
// one entry at a time over up to N loaded entries. One item at a time, no overlap.
// Reset (synchronous) clears state, counters, used marks, total and max_picks only.
`include "assert_macros.svh"
module weighted_sample_without_replacement_unit #(
   parameter int unsigned TABLE_DEPTH = wsw_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_attempt_count,
   input  logic [31:0] req_success_count,
   input  logic [31:0] req_failure_count,
   input  logic        req_source_static,
   input  logic [31:0] req_random_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_pick_index,
   output logic [14:0] rsp_pick_weight,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned LC_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV1, S_DIV2, S_WEIGH, S_DIVR, S_SCAN, S_SREAD, S_SDONE, S_OUT
   } state_type;

   state_type state_ff;
   logic [6:0]  max_picks_ff;
   logic [LC_W-1:0] loaded_ff;
   logic [20:0] total_ff;
   logic [6:0]  picks_ff;
   logic [TABLE_DEPTH-1:0] used_ff;
   logic [14:0] mem [TABLE_DEPTH];
   logic [14:0] rd_ff;
   logic [IDX_W-1:0] scan_ff;
   logic [IDX_W-1:0] chosen_ff;
   logic [14:0] chosen_w_ff;
   logic        found_ff;
   logic [21:0] cum_ff;
   logic [52:0] target_ff;
   logic        seq_mode_ff;
   logic [31:0] att_ff, fail_ff;
   logic        stat_ff;
   logic [63:0] ratio_ff;
   logic [1:0]  st_ff;
   logic [5:0]  idx_ff;
   logic [14:0] w_ff;
   logic        csr_wr;

   wsw_pkg::div_req_type div_req;
   wsw_pkg::div_rsp_type div_rsp;

   wsw_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr == 2'd0);
   assign csr_prdata = (csr_paddr == 2'd0) ? {25'd0, max_picks_ff} : 32'd0;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_OUT);
   assign rsp_status = st_ff;
   assign rsp_pick_index  = idx_ff;
   assign rsp_pick_weight = w_ff;

   // weight from the ratio quotient and the failure quotient
   logic [13:0] ratio_sat;
   logic [13:0] alt_w;
   logic [13:0] base_w;
   logic [14:0] final_w;
   always_comb begin
      ratio_sat = (ratio_ff > 64'd10000) ? wsw_pkg::RATIO_SCALE : ratio_ff[13:0];
      alt_w     = (div_rsp.quotient > 64'd10000) ? wsw_pkg::RATIO_SCALE
                                                 : div_rsp.quotient[13:0];
      base_w    = (alt_w > ratio_sat) ? alt_w : ratio_sat;
      if (base_w == 14'd0) base_w = 14'd1;
      final_w   = stat_ff ? {base_w, 1'b0} : {1'b0, base_w};
   end

   // weight of the load in flight, fixed weights skip the divider
   logic [14:0] load_w;
   assign load_w = (att_ff == 32'd0 || fail_ff == 32'd0)
      ? (stat_ff ? {ratio_ff[13:0], 1'b0} : ratio_ff[14:0]) : final_w;

   // divider requests
   always_comb begin
      div_req = '0;
      if (state_ff == S_IDLE && req_valid && req_func == wsw_pkg::FUNC_LOAD
          && req_attempt_count != 32'd0 && req_failure_count != 32'd0) begin
         div_req.start    = 1'b1;
         div_req.dividend = req_success_count * 64'd10000;
         div_req.divisor  = req_attempt_count;
      end else if (state_ff == S_DIV1 && div_rsp.done) begin
         div_req.start    = 1'b1;
         div_req.dividend = {32'd0, wsw_pkg::FAIL_SCALE};
         div_req.divisor  = fail_ff;
      end
   end

   // product over 2^32-1: high part plus one when high and low parts reach 2^32-1
   logic [32:0] fold_sum;
   logic        fold_carry;
   assign fold_sum   = {1'b0, target_ff[31:0]} + {12'd0, target_ff[52:32]};
   assign fold_carry = (fold_sum >= 33'h0_FFFF_FFFF);

   logic [IDX_W-1:0] last_idx;
   assign last_idx = IDX_W'(loaded_ff - LC_W'(1));
   logic [21:0] cum_next;
   assign cum_next = cum_ff + {7'd0, rd_ff};

   always_ff @(posedge clock) begin
      if (state_ff == S_WEIGH && 32'(loaded_ff) < TABLE_DEPTH)
         mem[loaded_ff[IDX_W-1:0]] <= load_w;
      rd_ff <= mem[scan_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_picks_ff <= '0;
         loaded_ff    <= '0;
         total_ff     <= '0;
         picks_ff     <= '0;
         used_ff      <= '0;
      end else begin
         if (csr_wr) max_picks_ff <= csr_pwdata[6:0];
         case (state_ff)
            S_IDLE: begin
               att_ff  <= req_attempt_count;
               fail_ff <= req_failure_count;
               stat_ff <= req_source_static;
               if (req_valid) begin
                  st_ff  <= wsw_pkg::ST_OK;
                  idx_ff <= '0;
                  w_ff   <= '0;
                  state_ff <= S_OUT;
                  case (req_func)
                     wsw_pkg::FUNC_CLEAR: begin
                        used_ff   <= '0;
                        loaded_ff <= '0;
                        total_ff  <= '0;
                        picks_ff  <= '0;
                     end
                     wsw_pkg::FUNC_LOAD: begin
                        if (req_attempt_count == 32'd0 || req_failure_count == 32'd0) begin
                           ratio_ff <= (req_attempt_count == 32'd0) ? 64'd5000 : 64'd10000;
                           state_ff <= S_WEIGH;
                        end else begin
                           state_ff <= S_DIV1;
                        end
                     end
                     wsw_pkg::FUNC_DRAW: begin
                        found_ff <= 1'b0;
                        cum_ff   <= '0;
                        scan_ff  <= '0;
                        if (picks_ff >= max_picks_ff || loaded_ff == '0) begin
                           st_ff <= wsw_pkg::ST_NONE;
                        end else if (32'(loaded_ff) <= 32'(max_picks_ff)) begin
                           seq_mode_ff <= 1'b1;
                           target_ff   <= '0;
                           state_ff    <= S_SREAD;
                        end else begin
                           seq_mode_ff <= 1'b0;
                           target_ff   <= {21'd0, req_random_value} * {32'd0, total_ff};
                           state_ff    <= S_DIVR;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_DIV1: if (div_rsp.done) begin
               ratio_ff <= div_rsp.quotient;
               state_ff <= S_DIV2;
            end
            S_DIV2: if (div_rsp.done) state_ff <= S_WEIGH;
            S_WEIGH: begin
               w_ff <= load_w;
               if (32'(loaded_ff) >= TABLE_DEPTH) begin
                  st_ff <= wsw_pkg::ST_FULL;
               end else begin
                  idx_ff    <= 6'(loaded_ff);
                  used_ff[loaded_ff[IDX_W-1:0]] <= 1'b0;
                  total_ff  <= total_ff + {6'd0, load_w};
                  loaded_ff <= loaded_ff + LC_W'(1);
               end
               state_ff <= S_OUT;
            end
            // scale the random value to the total
            S_DIVR: begin
               target_ff <= {32'd0, target_ff[52:32]} + {52'd0, fold_carry};
               state_ff  <= S_SREAD;
            end
            S_SREAD: state_ff <= S_SCAN;
            S_SCAN: begin
               logic stop;
               stop = 1'b0;
               if (!used_ff[scan_ff]) begin
                  chosen_ff   <= scan_ff;
                  chosen_w_ff <= rd_ff;
                  found_ff    <= 1'b1;
                  cum_ff      <= cum_next;
                  if (seq_mode_ff || {31'd0, cum_next} >= target_ff) stop = 1'b1;
               end
               if (stop || scan_ff == last_idx) begin
                  state_ff <= S_SDONE;
               end else begin
                  scan_ff  <= scan_ff + IDX_W'(1);
                  state_ff <= S_SREAD;
               end
            end
            S_SDONE: begin
               if (!found_ff) begin
                  st_ff <= wsw_pkg::ST_NONE;
               end else begin
                  used_ff[chosen_ff] <= 1'b1;
                  st_ff  <= wsw_pkg::ST_PICKED;
                  idx_ff <= 6'(chosen_ff);
                  w_ff   <= chosen_w_ff;
                  total_ff <= (total_ff >= {6'd0, chosen_w_ff})
                     ? total_ff - {6'd0, chosen_w_ff} : 21'd0;
                  if (picks_ff < 7'd127) picks_ff <= picks_ff + 7'd1;
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `WSW_ASSERT(a_no_accept_busy, clock, reset, (state_ff != S_IDLE) |-> req_stall, "accepted while busy")
   `WSW_ASSERT(a_loaded_bound, clock, reset, 32'(loaded_ff) <= TABLE_DEPTH, "loaded count overflow")
   `WSW_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_status), "result dropped")
endmodule

@@ src/wsw_divider.sv @@
// shared restoring divider, one quotient bit per cycle
module wsw_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  wsw_pkg::div_req_type div_req,
   output wsw_pkg::div_rsp_type div_rsp
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   // one shift and subtract step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
